// ----- hw/rtl/chfr_pkg.sv -----
// Shared types, constants and the sine table builder for the channel frequency response block.
// Used by chfr_store, chfr_mac and channel_freq_response_top; depends on nothing else.

package chfr_pkg;

    localparam int DEF_MAX_TAPS       = 32;
    localparam int DEF_MAX_LINKS      = 4;
    localparam int DEF_SINE_ADDR_BITS = 10;
    localparam int DEF_BIN_BITS       = 12;

    localparam int ACC_W   = 40;
    localparam int RESP_W  = 24;
    localparam int SINE_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int STEP_W  = 32;
    localparam int OUT_SHIFT = 9;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Denominators (2k)(2k+1) of the odd Taylor terms of the sine.
    localparam int unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

    typedef struct packed {
        logic gain_we;
        logic step_we;
        logic rd_en;
    } t_store_ctl;

    typedef struct packed {
        logic              clear;
        logic [STEP_W-1:0] bin;
    } t_mac_ctl;

    typedef struct packed {
        logic pending;
    } t_mac_status;

    // One quarter-wave entry in Q1.15, evaluated only at elaboration.
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned r,
                                                     input int unsigned abits);
        logic        [63:0] x;
        logic        [63:0] t;
        logic signed [63:0] sum;
        logic        [63:0] v;
        x   = (64'(r) * HALF_PI_Q30) >> (abits - 2);
        t   = x;
        sum = $signed(x);
        for (int k = 1; k <= 6; k++) begin
            t = (((t * x) >> 30) * x) >> 30;
            t = t / 64'(TAYLOR_DIV[k-1]);
            if ((k & 1) != 0) begin
                sum = sum - $signed(t);
            end else begin
                sum = sum + $signed(t);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        v = (64'(sum) + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return SINE_W'(v);
    endfunction

endpackage

// ----- hw/rtl/chfr_store.sv -----
// Tap gain memory (per link and tap) and phase step memory (per tap).
// Registered read port for the tap walk; uses chfr_pkg for the control struct.

module chfr_store #(
    parameter int MAX_TAPS  = chfr_pkg::DEF_MAX_TAPS,
    parameter int MAX_LINKS = chfr_pkg::DEF_MAX_LINKS,
    localparam int GAIN_DEPTH = MAX_TAPS * MAX_LINKS,
    localparam int GAIN_AW = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1,
    localparam int TAP_AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  chfr_pkg::t_store_ctl           i_ctl,
    input  logic [GAIN_AW-1:0]             i_wr_gain_addr,
    input  logic [TAP_AW-1:0]              i_wr_tap_addr,
    input  logic [2*chfr_pkg::GAIN_W-1:0]  i_wr_gain_data,
    input  logic [chfr_pkg::STEP_W-1:0]    i_wr_step_data,
    input  logic [GAIN_AW-1:0]             i_rd_gain_addr,
    input  logic [TAP_AW-1:0]              i_rd_tap_addr,
    output logic                           o_rd_valid,
    output logic [2*chfr_pkg::GAIN_W-1:0]  o_gain,
    output logic [chfr_pkg::STEP_W-1:0]    o_step
);

    logic [2*chfr_pkg::GAIN_W-1:0] r_gain_mem [GAIN_DEPTH];
    logic [chfr_pkg::STEP_W-1:0]   r_step_mem [MAX_TAPS];
    logic [2*chfr_pkg::GAIN_W-1:0] r_gain_q;
    logic [chfr_pkg::STEP_W-1:0]   r_step_q;
    logic                          r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.gain_we) begin
            r_gain_mem[i_wr_gain_addr] <= i_wr_gain_data;
        end
        if (i_ctl.rd_en) begin
            r_gain_q <= r_gain_mem[i_rd_gain_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step_we) begin
            r_step_mem[i_wr_tap_addr] <= i_wr_step_data;
        end
        if (i_ctl.rd_en) begin
            r_step_q <= r_step_mem[i_rd_tap_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_ctl.rd_en;
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_gain     = r_gain_q;
    assign o_step     = r_step_q;

endmodule

// ----- hw/rtl/chfr_mac.sv -----
// Shared complex multiply-accumulate pipeline: phase product, sine ROM lookup,
// four real products and the 40-bit accumulators. Uses chfr_pkg.

module chfr_mac #(
    parameter int SINE_ADDR_BITS = chfr_pkg::DEF_SINE_ADDR_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  chfr_pkg::t_mac_ctl                  i_ctl,
    input  logic                                i_tap_valid,
    input  logic [2*chfr_pkg::GAIN_W-1:0]       i_gain,
    input  logic [chfr_pkg::STEP_W-1:0]         i_step,
    output chfr_pkg::t_mac_status               o_status,
    output logic signed [chfr_pkg::ACC_W-1:0]   o_acc_real,
    output logic signed [chfr_pkg::ACC_W-1:0]   o_acc_imag
);

    localparam int A       = SINE_ADDR_BITS;
    localparam int IDX_W   = A - 1;
    localparam int QUARTER = 1 << (A - 2);
    localparam int SW      = chfr_pkg::SINE_W;
    localparam int GW      = chfr_pkg::GAIN_W;
    localparam int PW      = 2 * GW;
    localparam int AW      = chfr_pkg::ACC_W;
    localparam int ROM_W   = (QUARTER + 1) * SW;
    localparam logic [chfr_pkg::STEP_W-1:0] PH_ROUND = chfr_pkg::STEP_W'(64'd1 << (31 - A));

    function automatic logic [ROM_W-1:0] f_table();
        logic [ROM_W-1:0] tbl;
        tbl = '0;
        for (int r = 0; r <= QUARTER; r++) begin
            tbl[r*SW +: SW] = chfr_pkg::sine_entry(r, A);
        end
        return tbl;
    endfunction

    localparam logic [ROM_W-1:0] SINE_TABLE = f_table();

    // Quarter-wave lookup: odd quadrants run the table backward, the upper half negates.
    function automatic logic signed [SW-1:0] f_rom_sin(input logic [A-1:0] p);
        logic [1:0]      q;
        logic [A-3:0]    r;
        logic [IDX_W-1:0] idx;
        logic [SW-1:0]   v;
        q   = p[A-1 -: 2];
        r   = p[A-3:0];
        idx = q[0] ? (IDX_W'(QUARTER) - {1'b0, r}) : {1'b0, r};
        v   = SINE_TABLE[idx*SW +: SW];
        return q[1] ? -$signed(v) : $signed(v);
    endfunction

    logic                           r_va, r_vb, r_vc;
    logic [chfr_pkg::STEP_W-1:0]    r_ph;
    logic [PW-1:0]                  r_gain_a, r_gain_b;
    logic signed [SW-1:0]           r_sin, r_cos;
    logic signed [PW-1:0]           r_p_rc, r_p_is, r_p_ic, r_p_rs;
    logic signed [AW-1:0]           r_acc_real, r_acc_imag;

    logic [chfr_pkg::STEP_W-1:0]    n_ph;
    logic [chfr_pkg::STEP_W-1:0]    ph_round;
    logic [A-1:0]                   p_sin, p_cos;
    logic signed [SW-1:0]           n_sin, n_cos;
    logic signed [GW-1:0]           ar, ai;
    logic signed [PW-1:0]           n_p_rc, n_p_is, n_p_ic, n_p_rs;
    logic signed [AW-1:0]           n_acc_real, n_acc_imag;

    always_comb begin
        n_ph     = chfr_pkg::STEP_W'(i_step * i_ctl.bin);
        ph_round = r_ph + PH_ROUND;
        p_sin    = ph_round[chfr_pkg::STEP_W-1 -: A];
        p_cos    = p_sin + A'(QUARTER);
        n_sin    = f_rom_sin(p_sin);
        n_cos    = f_rom_sin(p_cos);
        ar       = $signed(r_gain_b[PW-1:GW]);
        ai       = $signed(r_gain_b[GW-1:0]);
        n_p_rc   = ar * r_cos;
        n_p_is   = ai * r_sin;
        n_p_ic   = ai * r_cos;
        n_p_rs   = ar * r_sin;
        n_acc_real = r_acc_real + AW'(r_p_rc) + AW'(r_p_is);
        n_acc_imag = r_acc_imag + AW'(r_p_ic) - AW'(r_p_rs);
    end

    always_ff @(posedge i_clk) begin
        r_ph     <= n_ph;
        r_gain_a <= i_gain;
        r_sin    <= n_sin;
        r_cos    <= n_cos;
        r_gain_b <= r_gain_a;
        r_p_rc   <= n_p_rc;
        r_p_is   <= n_p_is;
        r_p_ic   <= n_p_ic;
        r_p_rs   <= n_p_rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va       <= 1'b0;
            r_vb       <= 1'b0;
            r_vc       <= 1'b0;
            r_acc_real <= '0;
            r_acc_imag <= '0;
        end else begin
            r_va <= i_tap_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            if (i_ctl.clear) begin
                r_acc_real <= '0;
                r_acc_imag <= '0;
            end else if (r_vc) begin
                r_acc_real <= n_acc_real;
                r_acc_imag <= n_acc_imag;
            end
        end
    end

    assign o_status.pending = i_tap_valid | r_va | r_vb | r_vc;
    assign o_acc_real       = r_acc_real;
    assign o_acc_imag       = r_acc_imag;

endmodule

// ----- hw/rtl/channel_freq_response_top.sv -----
// Top level of the channel frequency response block: command decode, tap walk
// sequencer, output rounding and saturation. Uses chfr_pkg, chfr_store, chfr_mac.
//
// Usage: a request is taken when start is high and busy is low. Command 0 writes
// a Q1.15 complex gain for (link, tap), command 1 writes the phase step of a tap,
// both with busy staying low; command 3 is dropped. Command 2 evaluates one bin
// for one link: the sequencer walks n = min(tap_count, MAX_TAPS) taps (none for
// a link out of range) through the shared complex multiply-accumulate pipeline,
// one tap per cycle. The result appears on the o_resp_* ports for one cycle
// marked by o_resp_strobe, after the tap walk and the five stage memory read
// and MAC pipeline. busy is high until the strobe cycle, in which the next
// request can already be taken. The receiver cannot stall; a result is gone
// after its cycle. tap_count is written through the i_cfg_valid/o_cfg_ready
// channel; the user must write it only while idle, which the block itself
// does not enforce. Reset (synchronous, active low) sets tap_count to 1,
// clears the accumulators and the sequencer; the gain and step memories are
// not cleared.

module channel_freq_response_top #(
    parameter int MAX_TAPS       = chfr_pkg::DEF_MAX_TAPS,
    parameter int MAX_LINKS      = chfr_pkg::DEF_MAX_LINKS,
    parameter int SINE_ADDR_BITS = chfr_pkg::DEF_SINE_ADDR_BITS,
    parameter int BIN_BITS       = chfr_pkg::DEF_BIN_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [1:0]         i_link_index,
    input  logic [4:0]         i_tap_index,
    input  logic signed [15:0] i_gain_real,
    input  logic signed [15:0] i_gain_imag,
    input  logic [31:0]        i_phase_step,
    input  logic signed [11:0] i_bin_offset,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data,
    output logic               o_resp_strobe,
    output logic signed [23:0] o_resp_real,
    output logic signed [23:0] o_resp_imag,
    output logic [1:0]         o_resp_link,
    output logic signed [11:0] o_resp_bin,
    output logic               o_clipped
);

    localparam int GAIN_DEPTH = MAX_TAPS * MAX_LINKS;
    localparam int GAIN_AW = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;
    localparam int TAP_AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W   = $clog2(MAX_TAPS + 1);
    localparam int AW      = chfr_pkg::ACC_W;
    localparam int RW      = chfr_pkg::RESP_W;

    localparam logic [1:0] CMD_GAIN = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_EVAL = 2'd2;

    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1 << (chfr_pkg::OUT_SHIFT - 1));
    localparam logic signed [AW-1:0] SAT_HI     = AW'((64'd1 << (RW - 1)) - 64'd1);
    localparam logic signed [AW-1:0] SAT_LO     = -SAT_HI - AW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN
    } t_state;

    // Returns the clip flag above the rounded, saturated response.
    function automatic logic [RW:0] f_scale_sat(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] v;
        logic [RW:0]          res;
        v = (acc + ROUND_HALF) >>> chfr_pkg::OUT_SHIFT;
        if (v > SAT_HI) begin
            res = {1'b1, SAT_HI[RW-1:0]};
        end else if (v < SAT_LO) begin
            res = {1'b1, SAT_LO[RW-1:0]};
        end else begin
            res = {1'b0, v[RW-1:0]};
        end
        return res;
    endfunction

    t_state                r_state;
    logic [5:0]            r_tap_count;
    logic [CNT_W-1:0]      r_tap;
    logic [CNT_W-1:0]      r_n;
    logic [GAIN_AW-1:0]    r_gain_base;
    logic [1:0]            r_link;
    logic [BIN_BITS-1:0]   r_bin;
    logic                  r_strobe;
    logic [RW-1:0]         r_resp_real, r_resp_imag;
    logic [1:0]            r_resp_link;
    logic [11:0]           r_resp_bin;
    logic                  r_clipped;

    logic                  accept, eval_req, link_ok, tap_ok;
    logic [15:0]           bin16;
    logic [BIN_BITS-1:0]   bin_t;
    logic [6:0]            cnt7, lim7, n7;
    logic [CNT_W-1:0]      n_eff;
    logic [GAIN_AW-1:0]    link_base;
    logic [GAIN_AW-1:0]    wr_gain_addr, rd_gain_addr;
    logic [TAP_AW-1:0]     wr_tap_addr, rd_tap_addr;
    logic [RW:0]           sat_real, sat_imag;

    chfr_pkg::t_store_ctl  store_ctl;
    chfr_pkg::t_mac_ctl    mac_ctl;
    chfr_pkg::t_mac_status mac_status;
    logic                  rd_valid;
    logic [31:0]           rd_gain;
    logic [31:0]           rd_step;
    logic signed [AW-1:0]  acc_real, acc_imag;

    always_comb begin
        accept       = start && !busy;
        eval_req     = accept && (i_command == CMD_EVAL);
        link_ok      = 32'(i_link_index) < MAX_LINKS;
        tap_ok       = 32'(i_tap_index) < MAX_TAPS;
        bin16        = {4'b0, i_bin_offset};
        bin_t        = bin16[BIN_BITS-1:0];
        cnt7         = {1'b0, r_tap_count};
        lim7         = 7'(MAX_TAPS);
        n7           = (cnt7 > lim7) ? lim7 : cnt7;
        n_eff        = link_ok ? CNT_W'(n7) : '0;
        link_base    = GAIN_AW'(GAIN_AW'(i_link_index) * GAIN_AW'(MAX_TAPS));
        wr_gain_addr = link_base + GAIN_AW'(i_tap_index);
        wr_tap_addr  = TAP_AW'(i_tap_index);
        rd_tap_addr  = r_tap[TAP_AW-1:0];
        rd_gain_addr = r_gain_base + GAIN_AW'(rd_tap_addr);

        store_ctl.gain_we = accept && (i_command == CMD_GAIN) && link_ok && tap_ok;
        store_ctl.step_we = accept && (i_command == CMD_STEP) && tap_ok;
        store_ctl.rd_en   = (r_state == S_WALK);

        mac_ctl.clear = eval_req;
        mac_ctl.bin   = 32'(signed'(r_bin));

        sat_real = f_scale_sat(acc_real);
        sat_imag = f_scale_sat(acc_imag);
    end

    chfr_store #(
        .MAX_TAPS  (MAX_TAPS),
        .MAX_LINKS (MAX_LINKS)
    ) u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (store_ctl),
        .i_wr_gain_addr (wr_gain_addr),
        .i_wr_tap_addr  (wr_tap_addr),
        .i_wr_gain_data ({i_gain_real, i_gain_imag}),
        .i_wr_step_data (i_phase_step),
        .i_rd_gain_addr (rd_gain_addr),
        .i_rd_tap_addr  (rd_tap_addr),
        .o_rd_valid     (rd_valid),
        .o_gain         (rd_gain),
        .o_step         (rd_step)
    );

    chfr_mac #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_tap_valid (rd_valid),
        .i_gain      (rd_gain),
        .i_step      (rd_step),
        .o_status    (mac_status),
        .o_acc_real  (acc_real),
        .o_acc_imag  (acc_imag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_strobe    <= 1'b0;
            r_tap_count <= 6'd1;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (eval_req) begin
                        r_tap       <= '0;
                        r_n         <= n_eff;
                        r_gain_base <= link_base;
                        r_link      <= i_link_index;
                        r_bin       <= bin_t;
                        r_state     <= (n_eff == '0) ? S_DRAIN : S_WALK;
                    end
                end
                S_WALK: begin
                    r_tap <= r_tap + CNT_W'(1);
                    if (r_tap == r_n - CNT_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // The accumulators are final once the pipeline holds no tap.
                    if (!mac_status.pending) begin
                        r_strobe    <= 1'b1;
                        r_resp_real <= sat_real[RW-1:0];
                        r_resp_imag <= sat_imag[RW-1:0];
                        r_clipped   <= sat_real[RW] | sat_imag[RW];
                        r_resp_link <= r_link;
                        r_resp_bin  <= 12'(16'(r_bin));
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_resp_strobe = r_strobe;
    assign o_resp_real   = r_resp_real;
    assign o_resp_imag   = r_resp_imag;
    assign o_resp_link   = r_resp_link;
    assign o_resp_bin    = r_resp_bin;
    assign o_clipped     = r_clipped;

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_strobe |-> $past(busy))
        else $error("result strobe without an evaluation in progress");

    a_eval_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_EVAL) |=> busy)
        else $error("evaluate request did not start the sequencer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_strobe |=> !o_resp_strobe)
        else $error("result strobe held for more than one cycle");

    a_clip_is_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_strobe && o_clipped) |->
            (o_resp_real == 24'sh7FFFFF || o_resp_real == -24'sh800000 ||
             o_resp_imag == 24'sh7FFFFF || o_resp_imag == -24'sh800000))
        else $error("clip flag set without a saturated output");

endmodule

// ----- tb/tb_channel_freq_response_top.sv -----
// Self-checking testbench for channel_freq_response_top: gain and phase step writes, bin
// evaluations and tap_count settings, checked against an in-bench fixed-point predictor.
// Depends on chfr_pkg and channel_freq_response_top only.

module tb_channel_freq_response_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAP_LIMIT        = chfr_pkg::DEF_MAX_TAPS;
    localparam int LINK_COUNT       = chfr_pkg::DEF_MAX_LINKS;
    localparam int QUARTER_WAVE     = 256;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int SETTLE_CYCLES    = TAP_LIMIT + 8;
    localparam int RANDOM_PER_PHASE = 170;
    localparam int PHASE_COUNT      = 9;

    typedef enum logic [1:0] {
        CMD_WRITE_GAIN = 2'd0,
        CMD_WRITE_STEP = 2'd1,
        CMD_EVALUATE   = 2'd2,
        CMD_IGNORED    = 2'd3
    } command_e;

    typedef struct {
        command_e           command;
        logic [1:0]         link;
        logic [4:0]         tap;
        logic signed [15:0] gain_re;
        logic signed [15:0] gain_im;
        logic [31:0]        step;
        logic signed [11:0] bin;
    } request_t;

    typedef struct {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic [1:0]         link;
        logic signed [11:0] bin;
        logic               clipped;
    } response_t;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic [1:0]         i_command     = '0;
    logic [1:0]         i_link_index  = '0;
    logic [4:0]         i_tap_index   = '0;
    logic signed [15:0] i_gain_real   = '0;
    logic signed [15:0] i_gain_imag   = '0;
    logic [31:0]        i_phase_step  = '0;
    logic signed [11:0] i_bin_offset  = '0;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [5:0]         i_cfg_data    = '0;
    logic               o_resp_strobe;
    logic signed [23:0] o_resp_real;
    logic signed [23:0] o_resp_imag;
    logic [1:0]         o_resp_link;
    logic signed [11:0] o_resp_bin;
    logic               o_clipped;

    channel_freq_response_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_link_index  (i_link_index),
        .i_tap_index   (i_tap_index),
        .i_gain_real   (i_gain_real),
        .i_gain_imag   (i_gain_imag),
        .i_phase_step  (i_phase_step),
        .i_bin_offset  (i_bin_offset),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_resp_strobe (o_resp_strobe),
        .o_resp_real   (o_resp_real),
        .o_resp_imag   (o_resp_imag),
        .o_resp_link   (o_resp_link),
        .o_resp_bin    (o_resp_bin),
        .o_clipped     (o_clipped)
    );

    // Predictor state: the block's tables and its tap_count register.
    logic signed [15:0] quarter_sine [0:QUARTER_WAVE];
    logic signed [15:0] gain_re_mem [LINK_COUNT][TAP_LIMIT];
    logic signed [15:0] gain_im_mem [LINK_COUNT][TAP_LIMIT];
    logic [31:0]        step_mem [TAP_LIMIT];
    logic [5:0]         model_tap_count = 6'd1;

    // Which entries the stimulus has written, so no evaluation reads an unwritten one.
    bit gain_loaded [LINK_COUNT][TAP_LIMIT];
    bit step_loaded [TAP_LIMIT];
    int plan_taps = 1;

    request_t  pending_requests[$];
    response_t expected_responses[$];
    request_t  current_req;

    int planned;
    int accepted;
    int responses_checked;
    int clipped_seen;
    int mismatches;
    int settings_used;
    int idle_left;
    int calm_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void build_quarter_sine();
        longint unsigned x;
        longint unsigned term;
        longint          series;
        longint          rounded;
        for (int r = 0; r <= QUARTER_WAVE; r++) begin
            x      = (longint'(r) * QUARTER_TURN_Q30) >> 8;
            term   = x;
            series = longint'(x);
            // Odd Taylor terms of the sine in Q30, each step truncated.
            for (int k = 1; k <= 6; k++) begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    series = series - longint'(term);
                end else begin
                    series = series + longint'(term);
                end
            end
            if (series < 0) begin
                series = 0;
            end
            rounded = (series + 16384) / 32768;
            if (rounded > 32767) begin
                rounded = 32767;
            end
            quarter_sine[r] = 16'(rounded);
        end
    endfunction

    function automatic logic signed [15:0] sine_lookup(input logic [9:0] addr);
        logic signed [15:0] mag;
        mag = addr[8] ? quarter_sine[QUARTER_WAVE - addr[7:0]] : quarter_sine[addr[7:0]];
        return addr[9] ? -mag : mag;
    endfunction

    function automatic logic signed [23:0] round_saturate(input longint acc, inout bit clip);
        longint scaled;
        scaled = (acc + 256) >>> 9;
        if (scaled > 8388607) begin
            clip   = 1'b1;
            scaled = 8388607;
        end else if (scaled < -8388608) begin
            clip   = 1'b1;
            scaled = -8388608;
        end
        return scaled[23:0];
    endfunction

    function automatic void predict_request(request_t req);
        longint             acc_re;
        longint             acc_im;
        longint             ar;
        longint             ai;
        longint             s;
        longint             c;
        logic [31:0]        bin_wide;
        logic [31:0]        phase;
        logic [32:0]        phase_rounded;
        logic [9:0]         rom_addr;
        int                 n;
        bit                 clip;
        response_t          rsp;
        case (req.command)
            CMD_WRITE_GAIN: begin
                gain_re_mem[req.link][req.tap] = req.gain_re;
                gain_im_mem[req.link][req.tap] = req.gain_im;
            end
            CMD_WRITE_STEP: begin
                step_mem[req.tap] = req.step;
            end
            CMD_EVALUATE: begin
                acc_re   = 0;
                acc_im   = 0;
                clip     = 1'b0;
                n        = (model_tap_count > TAP_LIMIT) ? TAP_LIMIT : model_tap_count;
                bin_wide = {{20{req.bin[11]}}, req.bin};
                for (int l = 0; l < n; l++) begin
                    ar            = gain_re_mem[req.link][l];
                    ai            = gain_im_mem[req.link][l];
                    phase         = bin_wide * step_mem[l];
                    phase_rounded = {1'b0, phase} + 33'd2097152;
                    rom_addr      = phase_rounded[31:22];
                    s             = sine_lookup(rom_addr);
                    c             = sine_lookup(rom_addr + 10'd256);
                    // Multiply by exp(-j*phase).
                    acc_re        = acc_re + ar * c + ai * s;
                    acc_im        = acc_im + ai * c - ar * s;
                end
                rsp.re      = round_saturate(acc_re, clip);
                rsp.im      = round_saturate(acc_im, clip);
                rsp.link    = req.link;
                rsp.bin     = req.bin;
                rsp.clipped = clip;
                expected_responses.push_back(rsp);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic request_t random_request();
        request_t req;
        req.command = command_e'($urandom_range(0, 3));
        req.link    = $urandom;
        req.tap     = $urandom;
        req.gain_re = $urandom;
        req.gain_im = $urandom;
        req.step    = $urandom;
        req.bin     = $urandom;
        return req;
    endfunction

    function automatic void push_request(request_t req);
        if (req.command == CMD_WRITE_GAIN) begin
            gain_loaded[req.link][req.tap] = 1'b1;
        end else if (req.command == CMD_WRITE_STEP) begin
            step_loaded[req.tap] = 1'b1;
        end
        pending_requests.push_back(req);
        planned++;
    endfunction

    function automatic void plan_write_gain(input logic [1:0] link, input logic [4:0] tap,
                                            input logic signed [15:0] re,
                                            input logic signed [15:0] im);
        request_t req;
        req         = random_request();
        req.command = CMD_WRITE_GAIN;
        req.link    = link;
        req.tap     = tap;
        req.gain_re = re;
        req.gain_im = im;
        push_request(req);
    endfunction

    function automatic void plan_write_step(input logic [4:0] tap, input logic [31:0] step);
        request_t req;
        req         = random_request();
        req.command = CMD_WRITE_STEP;
        req.tap     = tap;
        req.step    = step;
        push_request(req);
    endfunction

    function automatic void plan_ignored();
        request_t req;
        req         = random_request();
        req.command = CMD_IGNORED;
        push_request(req);
    endfunction

    // Every tap that the evaluation will walk gets written first if it never was.
    function automatic void plan_evaluate(input logic [1:0] link, input logic signed [11:0] bin);
        request_t req;
        for (int l = 0; l < plan_taps; l++) begin
            if (!step_loaded[l]) begin
                plan_write_step(l, $urandom);
            end
            if (!gain_loaded[link][l]) begin
                plan_write_gain(link, l, $urandom, $urandom);
            end
        end
        req         = random_request();
        req.command = CMD_EVALUATE;
        req.link    = link;
        req.bin     = bin;
        push_request(req);
    endfunction

    function automatic logic signed [11:0] pick_bin();
        logic signed [11:0] corners [5] = '{-12'sd2048, 12'sd2047, 12'sd0, -12'sd1, 12'sd1};
        if ($urandom_range(0, 7) == 0) begin
            return corners[$urandom_range(0, 4)];
        end
        return $urandom;
    endfunction

    function automatic logic signed [15:0] pick_gain();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_step();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return '1;
        end else if (sel < 6) begin
            // Small steps keep the phase slowly varying across bins.
            return $urandom_range(0, 1 << 24);
        end
        return $urandom;
    endfunction

    function automatic logic [4:0] pick_tap();
        if ($urandom_range(0, 1) == 0 && plan_taps > 0) begin
            return $urandom_range(0, plan_taps - 1);
        end
        return $urandom;
    endfunction

    function automatic void plan_random_requests(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                plan_evaluate($urandom, pick_bin());
            end else if (pick < 70) begin
                plan_write_gain($urandom, pick_tap(), pick_gain(), pick_gain());
            end else if (pick < 94) begin
                plan_write_step(pick_tap(), pick_step());
            end else begin
                plan_ignored();
            end
        end
    endfunction

    function automatic int draw_idle();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(10, 40);
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : request_driver
        logic next_start;
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left = 0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                predict_request(current_req);
                accepted++;
                next_start = 1'b0;
            end
            if (!next_start && pending_requests.size() != 0) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else begin
                    current_req  = pending_requests.pop_front();
                    i_command    <= current_req.command;
                    i_link_index <= current_req.link;
                    i_tap_index  <= current_req.tap;
                    i_gain_real  <= current_req.gain_re;
                    i_gain_imag  <= current_req.gain_im;
                    i_phase_step <= current_req.step;
                    i_bin_offset <= current_req.bin;
                    next_start   = 1'b1;
                    idle_left    = draw_idle();
                end
            end
            start <= next_start;
        end
    end

    always @(posedge i_clk) begin : response_monitor
        response_t want;
        if (i_rst_n && o_resp_strobe) begin
            if (expected_responses.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected response, expected none, actual %0d %0d link %0d",
                         $time, o_resp_real, o_resp_imag, o_resp_link);
            end else begin
                want = expected_responses.pop_front();
                check_field("resp_real", want.re, o_resp_real);
                check_field("resp_imag", want.im, o_resp_imag);
                check_field("resp_link", want.link, o_resp_link);
                check_field("resp_bin", want.bin, o_resp_bin);
                check_field("clipped", want.clipped, o_clipped);
                responses_checked++;
                if (want.clipped) begin
                    clipped_seen++;
                end
            end
        end
    end

    // The sender holds off here until every request is taken and every response is back.
    task automatic wait_until_idle();
        do @(posedge i_clk); while (planned != accepted || expected_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tap_count(input logic [5:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid     <= 1'b0;
        model_tap_count = value;
        plan_taps       = (value > TAP_LIMIT) ? TAP_LIMIT : value;
        settings_used++;
    endtask

    initial begin
        logic [5:0] phase_taps [PHASE_COUNT] = '{6'd32, 6'd2, 6'd63, 6'd17, 6'd1, 6'd45, 6'd0,
                                                 6'd8, 6'd32};
        logic [5:0] taps;
        build_quarter_sine();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with tap_count at its reset value of one.
        plan_write_step(0, 32'h0000_0000);
        plan_write_gain(0, 0, 16'sh7FFF, 16'sh8000);
        plan_evaluate(0, 12'sd0);
        plan_evaluate(0, 12'sd2047);
        plan_evaluate(0, -12'sd2048);
        plan_write_gain(3, 31, 16'sh8000, 16'sh7FFF);
        plan_write_step(31, 32'hFFFF_FFFF);
        plan_write_step(0, 32'hFFFF_FFFF);
        plan_write_gain(3, 0, 16'sh8000, 16'sh8000);
        plan_evaluate(3, -12'sd1);
        plan_evaluate(3, 12'sd1);
        plan_write_step(0, 32'h4000_0000);
        plan_evaluate(0, 12'sd1);
        plan_evaluate(0, 12'sd3);
        plan_ignored();
        plan_ignored();
        plan_write_step(0, 32'h8000_0000);
        plan_evaluate(3, 12'sd2047);
        wait_until_idle();

        // With no taps the response is zero and comes back quickly.
        write_tap_count(6'd0);
        plan_evaluate(1, 12'sd5);
        plan_evaluate(2, -12'sd7);
        wait_until_idle();

        // Four full-scale taps at an eighth of a turn drive one part of each response into saturation.
        write_tap_count(6'd4);
        for (int t = 0; t < 4; t++) begin
            plan_write_step(t, 32'h2000_0000);
            plan_write_gain(2, t, 16'sh8000, 16'sh8000);
        end
        plan_evaluate(2, 12'sd1);
        plan_evaluate(2, -12'sd1);
        plan_evaluate(2, 12'sd3);
        wait_until_idle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            taps = (p >= PHASE_COUNT - 2) ? 6'($urandom_range(0, 63)) : phase_taps[p];
            write_tap_count(taps);
            plan_random_requests(RANDOM_PER_PHASE);
            wait_until_idle();
        end

        $display("Accepted %0d requests and checked %0d responses, %0d of them saturated,",
                 accepted, responses_checked, clipped_seen);
        $display("across %0d tap_count settings from zero to the saturating maximum.",
                 settings_used);
        if (mismatches == 0 && expected_responses.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d responses outstanding.", expected_responses.size());
        $display("status: fail");
        $finish;
    end

endmodule
